@@ hw/rtl/cspc_pkg.sv @@
// Shared types and constants of the cloud and surface pixel classifier.
package cspc_pkg;

  // Default sample width of reflectances and temperatures.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // Vegetation index thresholds are Q1.14 in a 16-bit field.
  localparam int unsigned IDX_WIDTH   = 16;
  localparam int unsigned INDEX_SHIFT = 14;

  localparam int unsigned CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_WATER_REFL_MAX  = 3'd0,
    REG_WATER_DIFF_MIN  = 3'd1,
    REG_LAND_INDEX_MIN  = 3'd2,
    REG_BRIGHT_REFL_MAX = 3'd3,
    REG_TEMP_DIFF_MIN   = 3'd4,
    REG_ICE_TEMP_MAX    = 3'd5,
    REG_ICE_INDEX_MAX   = 3'd6,
    REG_TEST_MODE       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SURF_LAND    = 2'd0,
    SURF_SEA     = 2'd1,
    SURF_UNKNOWN = 2'd2,
    SURF_OTHER   = 2'd3
  } surf_e;

  typedef enum logic [2:0] {
    CLS_LAND   = 3'd0,
    CLS_SEA    = 3'd1,
    CLS_INLAND = 3'd2,
    CLS_ICE    = 3'd3,
    CLS_SNOW   = 3'd4,
    CLS_CLOUD  = 3'd5
  } cls_e;

  localparam logic [0:0] MODE_FULL = 1'b0;

  // Outcome of comparing the vegetation index against one threshold.
  typedef struct packed {
    logic gt;
    logic lt;
  } idx_cmp_t;

endpackage

@@ hw/rtl/cspc_in_if.sv @@
// Pixel input channel: valid, ready and the pixel fields.
interface cspc_in_if #(
  parameter int unsigned SAMPLE_WIDTH = cspc_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] refl_vis;
  logic signed [SAMPLE_WIDTH-1:0] refl_nir;
  logic signed [SAMPLE_WIDTH-1:0] temp_mid_ir;
  logic signed [SAMPLE_WIDTH-1:0] temp_thermal;
  logic [1:0]                     surface_code;

  modport source (
    output valid, refl_vis, refl_nir, temp_mid_ir, temp_thermal, surface_code,
    input  ready
  );
  modport sink (
    input  valid, refl_vis, refl_nir, temp_mid_ir, temp_thermal, surface_code,
    output ready
  );
endinterface

@@ hw/rtl/cspc_out_if.sv @@
// Class result channel: valid, ready and the pixel class.
interface cspc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] pixel_class;

  modport source (
    output valid, pixel_class,
    input  ready
  );
  modport sink (
    input  valid, pixel_class,
    output ready
  );
endinterface

@@ hw/rtl/cloud_surface_pixel_classifier.sv @@
// Top level of the cloud and surface pixel classifier.
// Classifies one pixel per clock while the sink is ready: a beat accepted on
// pix_in is captured in an input register, classified by one pass of compare
// logic and the two vegetation index multipliers, and held in a result
// register that drives the class on cls_out. The input side keeps taking
// beats while a result waits, as long as the input register is empty or can
// move on. The user must write the thresholds and test mode through the cfg
// port while no pixel is in flight; this is not enforced. All reset to zero.
module cloud_surface_pixel_classifier #(
  parameter int unsigned SAMPLE_WIDTH = cspc_pkg::SAMPLE_WIDTH_DEF,
  localparam int unsigned CfgWidth = (SAMPLE_WIDTH + 1 > cspc_pkg::IDX_WIDTH) ?
                                     SAMPLE_WIDTH + 1 : cspc_pkg::IDX_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cspc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]                cfg_wdata_i,
  cspc_in_if.sink                            pix_in,
  cspc_out_if.source                         cls_out
);
  import cspc_pkg::*;

  // Configuration registers.
  logic signed [SAMPLE_WIDTH-1:0] water_refl_max_q;
  logic signed [SAMPLE_WIDTH-1:0] water_diff_min_q;
  logic signed [IDX_WIDTH-1:0]    land_index_min_q;
  logic signed [SAMPLE_WIDTH-1:0] bright_refl_max_q;
  logic signed [SAMPLE_WIDTH:0]   temp_diff_min_q;
  logic signed [SAMPLE_WIDTH-1:0] ice_temp_max_q;
  logic signed [IDX_WIDTH-1:0]    ice_index_max_q;
  logic                           test_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      water_refl_max_q  <= '0;
      water_diff_min_q  <= '0;
      land_index_min_q  <= '0;
      bright_refl_max_q <= '0;
      temp_diff_min_q   <= '0;
      ice_temp_max_q    <= '0;
      ice_index_max_q   <= '0;
      test_mode_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_WATER_REFL_MAX:  water_refl_max_q  <= cfg_wdata_i[SAMPLE_WIDTH-1:0];
        REG_WATER_DIFF_MIN:  water_diff_min_q  <= cfg_wdata_i[SAMPLE_WIDTH-1:0];
        REG_LAND_INDEX_MIN:  land_index_min_q  <= cfg_wdata_i[IDX_WIDTH-1:0];
        REG_BRIGHT_REFL_MAX: bright_refl_max_q <= cfg_wdata_i[SAMPLE_WIDTH-1:0];
        REG_TEMP_DIFF_MIN:   temp_diff_min_q   <= cfg_wdata_i[SAMPLE_WIDTH:0];
        REG_ICE_TEMP_MAX:    ice_temp_max_q    <= cfg_wdata_i[SAMPLE_WIDTH-1:0];
        REG_ICE_INDEX_MAX:   ice_index_max_q   <= cfg_wdata_i[IDX_WIDTH-1:0];
        REG_TEST_MODE:       test_mode_q       <= cfg_wdata_i[0];
        default:             test_mode_q       <= test_mode_q;
      endcase
    end
  end

  // Input register stage.
  logic                           s1_valid_q;
  logic                           s1_adv;
  logic signed [SAMPLE_WIDTH-1:0] vis_q;
  logic signed [SAMPLE_WIDTH-1:0] nir_q;
  logic signed [SAMPLE_WIDTH-1:0] t3_q;
  logic signed [SAMPLE_WIDTH-1:0] t4_q;
  logic [1:0]                     code_q;

  // Result register stage.
  logic       s2_valid_q;
  logic [2:0] class_q;
  cls_e       class_d;

  assign s1_adv       = !s2_valid_q || cls_out.ready;
  assign pix_in.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (pix_in.ready) begin
        s1_valid_q <= pix_in.valid;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_in.ready && pix_in.valid) begin
      vis_q  <= pix_in.refl_vis;
      nir_q  <= pix_in.refl_nir;
      t3_q   <= pix_in.temp_mid_ir;
      t4_q   <= pix_in.temp_thermal;
      code_q <= pix_in.surface_code;
    end
    if (s1_adv && s1_valid_q) begin
      class_q <= class_d;
    end
  end

  // Classification of the registered pixel.
  idx_cmp_t land_cmp;
  idx_cmp_t ice_cmp;

  cspc_index_cmp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_land_cmp (
    .refl_vis_i (vis_q),
    .refl_nir_i (nir_q),
    .thr_i      (land_index_min_q),
    .cmp_o      (land_cmp)
  );

  cspc_index_cmp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ice_cmp (
    .refl_vis_i (vis_q),
    .refl_nir_i (nir_q),
    .thr_i      (ice_index_max_q),
    .cmp_o      (ice_cmp)
  );

  logic signed [SAMPLE_WIDTH:0] vis_minus_nir;
  logic signed [SAMPLE_WIDTH:0] t3_minus_t4;
  logic                         full_mode;
  logic                         is_water;
  logic                         is_open_land;
  logic                         is_frozen;
  logic                         is_cloud;
  cls_e                         water_cls;

  assign vis_minus_nir = {vis_q[SAMPLE_WIDTH-1], vis_q} - {nir_q[SAMPLE_WIDTH-1], nir_q};
  assign t3_minus_t4   = {t3_q[SAMPLE_WIDTH-1], t3_q} - {t4_q[SAMPLE_WIDTH-1], t4_q};
  assign full_mode     = (test_mode_q == MODE_FULL);

  always_comb begin
    is_water  = (nir_q < water_refl_max_q) &&
                (vis_minus_nir > $signed({water_diff_min_q[SAMPLE_WIDTH-1], water_diff_min_q}));
    water_cls = ((code_q == SURF_SEA) || (code_q == SURF_UNKNOWN)) ? CLS_SEA : CLS_INLAND;
    // The land mask admits land and unknown codes; other surfaces never pass.
    is_open_land = full_mode && !is_water &&
                   ((code_q == SURF_LAND) || (code_q == SURF_UNKNOWN)) &&
                   land_cmp.gt && (vis_q < bright_refl_max_q);
    is_frozen = full_mode && (t4_q < ice_temp_max_q) && ice_cmp.lt;
    is_cloud  = (vis_q > bright_refl_max_q) || (t3_minus_t4 > temp_diff_min_q);

    priority if (is_water) begin
      class_d = is_frozen ? CLS_ICE : water_cls;
    end else if (is_open_land) begin
      class_d = is_frozen ? CLS_SNOW : CLS_LAND;
    end else begin
      class_d = is_cloud ? CLS_CLOUD : CLS_LAND;
    end
  end

  assign cls_out.valid       = s2_valid_q;
  assign cls_out.pixel_class = class_q;
endmodule

@@ hw/rtl/cspc_index_cmp.sv @@
// Exact compare of the vegetation index (nir-vis)/(nir+vis) against a Q1.14 threshold.
module cspc_index_cmp #(
  parameter int unsigned SAMPLE_WIDTH = cspc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0]        refl_vis_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        refl_nir_i,
  input  logic signed [cspc_pkg::IDX_WIDTH-1:0] thr_i,
  output cspc_pkg::idx_cmp_t                    cmp_o
);
  import cspc_pkg::*;

  localparam int unsigned PW = SAMPLE_WIDTH + IDX_WIDTH + 1;

  logic signed [SAMPLE_WIDTH:0] sum;
  logic signed [SAMPLE_WIDTH:0] diff;
  logic signed [PW-1:0]         lhs;
  logic signed [PW-1:0]         rhs;
  logic                         sum_pos;
  logic                         sum_neg;

  assign sum  = {refl_nir_i[SAMPLE_WIDTH-1], refl_nir_i}
              + {refl_vis_i[SAMPLE_WIDTH-1], refl_vis_i};
  assign diff = {refl_nir_i[SAMPLE_WIDTH-1], refl_nir_i}
              - {refl_vis_i[SAMPLE_WIDTH-1], refl_vis_i};

  // Cross-multiplied form: diff * 2^14 against thr * sum, flipped when sum is negative.
  assign lhs = {{(PW-SAMPLE_WIDTH-1){diff[SAMPLE_WIDTH]}}, diff} <<< INDEX_SHIFT;
  assign rhs = thr_i * sum;

  assign sum_neg = sum[SAMPLE_WIDTH];
  assign sum_pos = !sum[SAMPLE_WIDTH] && (sum != '0);

  always_comb begin
    cmp_o.gt = (sum_pos && (lhs > rhs)) || (sum_neg && (lhs < rhs));
    cmp_o.lt = (sum_pos && (lhs < rhs)) || (sum_neg && (lhs > rhs));
  end
endmodule

@@ hw/rtl/cspc_checker.sv @@
// Port-level checks of the pixel classifier and their bind to the top level.
module cspc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] pixel_class_i
);
  import cspc_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // A stalled result beat keeps its class until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_class_i))
    else $error("result beat changed while stalled");

  // Only defined classes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pixel_class_i <= CLS_CLOUD)
    else $error("undefined pixel class");

  // When the sink takes results the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

  // A fresh result follows an input beat through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##2 (out_valid_i && !$past(out_valid_i)) |-> $past(in_beat, 2))
    else $error("result without a matching input beat");
endmodule

bind cloud_surface_pixel_classifier cspc_checker u_cspc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_in.valid),
  .in_ready_i    (pix_in.ready),
  .out_valid_i   (cls_out.valid),
  .out_ready_i   (cls_out.ready),
  .pixel_class_i (cls_out.pixel_class)
);

@@ tb/cloud_surface_pixel_classifier_tb.sv @@
// Self-checking testbench of the cloud and surface pixel classifier.
module cloud_surface_pixel_classifier_tb;
  import cspc_pkg::*;

  localparam int SW         = SAMPLE_WIDTH_DEF;
  localparam int CFG_W      = SW + 1;
  localparam int INDEX_ONE  = 1 << INDEX_SHIFT;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_OFF   = 300;
  localparam int NUM_REGS   = 8;

  localparam int REG_LOW[NUM_REGS]     = '{-32768, -32768, -16384, -32768, -65536, -32768,
                                           -16384, 0};
  localparam int REG_HIGH[NUM_REGS]    = '{32767, 32767, 16384, 32767, 65535, 32767,
                                           16384, 1};
  localparam int REG_TYPICAL[NUM_REGS] = '{800, 0, 4915, 2500, 1500, -1000, 1638, 0};

  typedef struct {
    int    vis;
    int    nir;
    int    t3;
    int    t4;
    surf_e code;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  cspc_in_if #(.SAMPLE_WIDTH(SW)) pix_if ();
  cspc_out_if cls_if ();

  cloud_surface_pixel_classifier #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_in     (pix_if),
    .cls_out    (cls_if)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the configuration registers, indexed by register.
  int     reg_q[NUM_REGS];
  pixel_t pending_pixels[$];
  cls_e   expected_classes[$];
  int     pixels_queued;
  int     classes_seen;
  int     mismatches;
  int     idle_cycles;
  bit     in_taken;
  int     send_gap;
  int     send_calm;
  int     recv_gap;
  int     recv_calm;
  int     hold_off_left;
  bit     hold_off_done;

  // Sign of (index - thr/16384); zero when equal or when the sum is zero.
  function automatic int index_sign(longint vis, longint nir, longint thr);
    longint s;
    longint lhs;
    longint rhs;
    int c;
    s = nir + vis;
    if (s == 0) return 0;
    lhs = (nir - vis) * INDEX_ONE;
    rhs = thr * s;
    c = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    return (s > 0) ? c : -c;
  endfunction

  function automatic cls_e classify_pixel(pixel_t p);
    longint vis;
    longint nir;
    longint bright;
    bit settled;
    cls_e cls;
    vis = p.vis;
    nir = p.nir;
    bright = reg_q[REG_BRIGHT_REFL_MAX];
    settled = 1'b0;
    cls = CLS_LAND;
    if (nir < reg_q[REG_WATER_REFL_MAX] && (vis - nir) > reg_q[REG_WATER_DIFF_MIN]) begin
      settled = 1'b1;
      cls = (p.code == SURF_SEA || p.code == SURF_UNKNOWN) ? CLS_SEA : CLS_INLAND;
    end
    if (reg_q[REG_TEST_MODE] == MODE_FULL) begin
      if (!settled && (p.code == SURF_LAND || p.code == SURF_UNKNOWN) &&
          index_sign(vis, nir, reg_q[REG_LAND_INDEX_MIN]) > 0 && vis < bright) begin
        settled = 1'b1;
        cls = CLS_LAND;
      end
      if (settled && p.t4 < reg_q[REG_ICE_TEMP_MAX] &&
          index_sign(vis, nir, reg_q[REG_ICE_INDEX_MAX]) < 0) begin
        cls = (cls == CLS_LAND) ? CLS_SNOW : CLS_ICE;
      end
    end
    if (!settled) begin
      if (vis > bright || longint'(p.t3) - p.t4 > reg_q[REG_TEMP_DIFF_MIN]) begin
        cls = CLS_CLOUD;
      end else begin
        cls = CLS_LAND;
      end
    end
    return cls;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int near(int center, int spread);
    return clamp(center + int'($urandom_range(0, 2 * spread)) - spread, -32768, 32767);
  endfunction

  function automatic int any_sample();
    logic signed [SW-1:0] r;
    r = SW'($urandom());
    return int'(r);
  endfunction

  function automatic int edge_sample();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return -1;
      2: return 0;
      default: return 32767;
    endcase
  endfunction

  function automatic int pick_threshold(int lo, int hi, int typical);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2, 3, 4: return lo + int'($urandom_range(0, hi - lo));
      default: return clamp(typical + int'($urandom_range(0, 800)) - 400, lo, hi);
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) calm = $urandom_range(20, 80);
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_pixel(int vis, int nir, int t3, int t4, surf_e code);
    pixel_t p;
    p.vis = vis;
    p.nir = nir;
    p.t3 = t3;
    p.t4 = t4;
    p.code = code;
    pending_pixels.push_back(p);
    pixels_queued++;
  endtask

  // Random pixels, mostly placed around the current thresholds.
  task automatic add_random_pixel();
    int style;
    int vis;
    int nir;
    int t3;
    int t4;
    surf_e code;
    code = surf_e'($urandom_range(0, 3));
    t4 = near(reg_q[REG_ICE_TEMP_MAX], 1500);
    t3 = clamp(t4 + reg_q[REG_TEMP_DIFF_MIN] + int'($urandom_range(0, 400)) - 200,
               -32768, 32767);
    style = $urandom_range(0, 99);
    if (style < 25) begin
      vis = any_sample();
      nir = any_sample();
      t3 = any_sample();
      t4 = any_sample();
    end else if (style < 45) begin
      nir = near(reg_q[REG_WATER_REFL_MAX] - 100, 300);
      vis = clamp(nir + reg_q[REG_WATER_DIFF_MIN] + int'($urandom_range(0, 400)) - 100,
                  -32768, 32767);
    end else if (style < 70) begin
      vis = $urandom_range(0, 4000);
      nir = ($urandom_range(0, 3) == 0) ? vis : vis + int'($urandom_range(0, 8000));
    end else if (style < 85) begin
      vis = near(reg_q[REG_BRIGHT_REFL_MAX], 300);
      nir = near(vis, 2000);
    end else if (style < 90) begin
      // Zero index denominator.
      vis = clamp(any_sample(), -32767, 32767);
      nir = -vis;
    end else begin
      vis = edge_sample();
      nir = edge_sample();
      t3 = edge_sample();
      t4 = edge_sample();
    end
    add_pixel(vis, nir, t3, t4, code);
  endtask

  // Call at a falling edge; leaves the write enable low at a falling edge.
  task automatic apply_config(int vals[NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i][CFG_W-1:0];
      cfg_we_i <= 1'b1;
      reg_q[i] = (i == REG_TEST_MODE) ? (vals[i] & 1) : vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    while (classes_seen != pixels_queued) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Pixel driver.
  always @(negedge clk_i) begin
    pixel_t px;
    if (rst_ni && (!pix_if.valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        pix_if.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        px = pending_pixels.pop_front();
        pix_if.refl_vis <= px.vis[SW-1:0];
        pix_if.refl_nir <= px.nir[SW-1:0];
        pix_if.temp_mid_ir <= px.t3[SW-1:0];
        pix_if.temp_thermal <= px.t4[SW-1:0];
        pix_if.surface_code <= px.code;
        pix_if.valid <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Class receiver; holds off once for a long stretch while pixels keep coming.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_left > 0) begin
        hold_off_left--;
        cls_if.ready <= 1'b0;
      end else if (!hold_off_done && pending_pixels.size() > 100) begin
        hold_off_done = 1'b1;
        hold_off_left = HOLD_OFF;
        cls_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        cls_if.ready <= 1'b0;
      end else begin
        cls_if.ready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // Monitor: predicts on each accepted pixel beat and checks each class beat.
  always @(posedge clk_i) begin
    pixel_t p;
    cls_e want;
    bit out_taken;
    if (rst_ni) begin
      in_taken = pix_if.valid && pix_if.ready;
      out_taken = cls_if.valid && cls_if.ready;
      if (in_taken) begin
        p.vis = pix_if.refl_vis;
        p.nir = pix_if.refl_nir;
        p.t3 = pix_if.temp_mid_ir;
        p.t4 = pix_if.temp_thermal;
        p.code = surf_e'(pix_if.surface_code);
        expected_classes.push_back(classify_pixel(p));
      end
      if (out_taken) begin
        classes_seen++;
        if (expected_classes.size() == 0) begin
          $error("pixel_class beat with no pixel pending: expected none, actual %0d",
                 cls_if.pixel_class);
          mismatches++;
        end else begin
          want = expected_classes.pop_front();
          if (cls_if.pixel_class !== want) begin
            $error("pixel_class mismatch: expected %0d, actual %0d", want,
                   cls_if.pixel_class);
            mismatches++;
          end
        end
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int vals[NUM_REGS];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WATER_REFL_MAX;
    cfg_wdata_i = '0;
    pix_if.valid = 1'b0;
    pix_if.refl_vis = '0;
    pix_if.refl_nir = '0;
    pix_if.temp_mid_ir = '0;
    pix_if.temp_thermal = '0;
    pix_if.surface_code = SURF_LAND;
    cls_if.ready = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) reg_q[i] = 0;
    pixels_queued = 0;
    classes_seen = 0;
    mismatches = 0;
    idle_cycles = 0;
    in_taken = 1'b0;
    send_gap = 0;
    send_calm = 0;
    recv_gap = 0;
    recv_calm = 0;
    hold_off_left = 0;
    hold_off_done = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes with every threshold at its reset value.
    add_pixel(32767, 32767, 32767, -32768, SURF_UNKNOWN);
    add_pixel(-32768, -32768, -32768, 32767, SURF_OTHER);
    add_pixel(32767, -32768, 0, 0, SURF_SEA);
    add_pixel(-32768, 32767, -1, -1, SURF_LAND);
    wait_until_drained();

    // Typical thresholds with an ice index limit above the land limit, so snow can occur.
    vals = '{800, 0, 4915, 2500, 1500, -1000, 8192, 0};
    apply_config(vals);
    add_pixel(600, 300, 0, 0, SURF_SEA);
    add_pixel(600, 300, 0, 0, SURF_LAND);
    add_pixel(600, 300, 0, 0, SURF_UNKNOWN);
    add_pixel(600, 300, 0, 0, SURF_OTHER);
    add_pixel(600, 300, 0, -2000, SURF_SEA);
    add_pixel(1500, 3500, 0, 0, SURF_LAND);
    add_pixel(1500, 3500, 0, -2000, SURF_UNKNOWN);
    add_pixel(1500, 3500, 0, 0, SURF_OTHER);
    add_pixel(5000, 5500, 0, 0, SURF_LAND);
    add_pixel(1000, 1100, 3000, 0, SURF_LAND);
    // Zero index denominator, once settled as water and once left to the cloud test.
    add_pixel(400, -400, 0, -2000, SURF_LAND);
    add_pixel(-400, 400, 0, 0, SURF_UNKNOWN);
    wait_until_drained();

    // Water and cloud tests only.
    vals[REG_TEST_MODE] = 1;
    apply_config(vals);
    add_pixel(1500, 3500, 0, 0, SURF_LAND);
    add_pixel(600, 300, 0, -2000, SURF_SEA);
    add_pixel(5000, 5500, 0, 0, SURF_UNKNOWN);
    add_pixel(1000, 1100, 3000, 0, SURF_OTHER);
    wait_until_drained();

    // Every register at the lowest, then at the highest value of its test range.
    for (int e = 0; e < 2; e++) begin
      if (e == 0) begin
        vals = REG_LOW;
      end else begin
        vals = REG_HIGH;
      end
      apply_config(vals);
      repeat (150) add_random_pixel();
      wait_until_drained();
    end

    repeat (11) begin
      for (int i = 0; i < REG_TEST_MODE; i++) begin
        vals[i] = pick_threshold(REG_LOW[i], REG_HIGH[i], REG_TYPICAL[i]);
      end
      vals[REG_TEST_MODE] = ($urandom_range(0, 9) < 3) ? 1 : 0;
      apply_config(vals);
      repeat (155) add_random_pixel();
      wait_until_drained();
    end

    repeat (6) @(negedge clk_i);
    if (expected_classes.size() != 0) begin
      $error("pixel_class beats missing: expected %0d more, actual 0",
             expected_classes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
